>>> rtl/gbp_pkg.sv
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared types, codes and constants of the grid BFS path finder.
// ----------------------------------------------------------------------------
package gbp_pkg;

    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;

    localparam int COORD_W  = 4;
    localparam int KIND_W   = 2;
    localparam int STEP_W   = 8;
    localparam int CLASS_W  = 2;
    localparam int DIST_W   = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int LIMIT_W  = 5;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam logic [CLASS_W-1:0] CLASS_FREE    = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_WALL    = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_PATH    = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_REACHED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_ROW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_COL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 3'd5;

    localparam logic [LIMIT_W-1:0] ROWS_RESET = 5'd10;
    localparam logic [LIMIT_W-1:0] COLS_RESET = 5'd14;

    localparam int NUM_DIRS = 8;
    localparam logic signed [1:0] DIR_ROW [NUM_DIRS] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0,
                                                          -2'sd1, 2'sd1, 2'sd1, -2'sd1};
    localparam logic signed [1:0] DIR_COL [NUM_DIRS] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1,
                                                          2'sd1, 2'sd1, -2'sd1, -2'sd1};

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_RD_DONE, ST_POP, ST_LAB_RD, ST_LAB_WAIT,
        ST_NB, ST_NB_WAIT, ST_TR_RD, ST_TR_CHK, ST_TB_RD, ST_TB_CHK, ST_TB_NB,
        ST_TB_NBW, ST_RESP
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_LOAD, OP_WRITE, OP_RD_ISSUE, OP_RD_DONE, OP_RUN_INIT,
        OP_POP, OP_LAB_RD, OP_LAB_WAIT, OP_NB, OP_NB_WAIT, OP_TR_RD, OP_TR_CHK,
        OP_TB_RD, OP_TB_CHK, OP_TB_NB, OP_TB_NBW
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic clr_last;
        logic start_in;
        logic stop_in;
        logic q_more;
        logic nb_ok;
        logic dir_last;
        logic tr_label;
        logic tb_end;
        logic tb_match;
    } status_t;

endpackage

>>> rtl/gbp_ctrl.sv
// ----------------------------------------------------------------------------
// gbp_ctrl
// Sequencer: clear pass, item dispatch, flood, backtrace and result transfer.
// ----------------------------------------------------------------------------
module gbp_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  gbp_pkg::status_t st,
    output gbp_pkg::cmd_t    cmd
);

    gbp_pkg::state_t state_reg;
    gbp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbp_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = gbp_pkg::OP_NONE;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            gbp_pkg::ST_CLEAR:
            begin
                cmd.op = gbp_pkg::OP_CLEAR;
                if (st.clr_last)
                begin
                    state_next = gbp_pkg::ST_IDLE;
                end
            end
            gbp_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = gbp_pkg::OP_LOAD;
                    state_next = gbp_pkg::ST_DISPATCH;
                end
            end
            gbp_pkg::ST_DISPATCH:
            begin
                state_next = gbp_pkg::ST_RESP;
                case (st.kind)
                    gbp_pkg::KIND_WRITE:
                    begin
                        cmd.op = gbp_pkg::OP_WRITE;
                    end
                    gbp_pkg::KIND_READ:
                    begin
                        cmd.op     = gbp_pkg::OP_RD_ISSUE;
                        state_next = gbp_pkg::ST_RD_DONE;
                    end
                    gbp_pkg::KIND_RUN:
                    begin
                        if (st.start_in)
                        begin
                            cmd.op     = gbp_pkg::OP_RUN_INIT;
                            state_next = gbp_pkg::ST_POP;
                        end
                    end
                    default:
                    begin
                        state_next = gbp_pkg::ST_RESP;
                    end
                endcase
            end
            gbp_pkg::ST_RD_DONE:
            begin
                cmd.op     = gbp_pkg::OP_RD_DONE;
                state_next = gbp_pkg::ST_RESP;
            end
            gbp_pkg::ST_POP:
            begin
                if (st.q_more)
                begin
                    cmd.op     = gbp_pkg::OP_POP;
                    state_next = gbp_pkg::ST_LAB_RD;
                end
                else
                begin
                    state_next = gbp_pkg::ST_TR_RD;
                end
            end
            gbp_pkg::ST_LAB_RD:
            begin
                cmd.op     = gbp_pkg::OP_LAB_RD;
                state_next = gbp_pkg::ST_LAB_WAIT;
            end
            gbp_pkg::ST_LAB_WAIT:
            begin
                cmd.op     = gbp_pkg::OP_LAB_WAIT;
                state_next = gbp_pkg::ST_NB;
            end
            gbp_pkg::ST_NB:
            begin
                cmd.op = gbp_pkg::OP_NB;
                if (st.nb_ok)
                begin
                    state_next = gbp_pkg::ST_NB_WAIT;
                end
                else if (st.dir_last)
                begin
                    state_next = gbp_pkg::ST_POP;
                end
            end
            gbp_pkg::ST_NB_WAIT:
            begin
                cmd.op     = gbp_pkg::OP_NB_WAIT;
                state_next = st.dir_last ? gbp_pkg::ST_POP : gbp_pkg::ST_NB;
            end
            gbp_pkg::ST_TR_RD:
            begin
                state_next = gbp_pkg::ST_RESP;
                if (st.stop_in)
                begin
                    cmd.op     = gbp_pkg::OP_TR_RD;
                    state_next = gbp_pkg::ST_TR_CHK;
                end
            end
            gbp_pkg::ST_TR_CHK:
            begin
                cmd.op     = gbp_pkg::OP_TR_CHK;
                state_next = st.tr_label ? gbp_pkg::ST_TB_RD : gbp_pkg::ST_RESP;
            end
            gbp_pkg::ST_TB_RD:
            begin
                cmd.op     = gbp_pkg::OP_TB_RD;
                state_next = gbp_pkg::ST_TB_CHK;
            end
            gbp_pkg::ST_TB_CHK:
            begin
                cmd.op     = gbp_pkg::OP_TB_CHK;
                state_next = st.tb_end ? gbp_pkg::ST_RESP : gbp_pkg::ST_TB_NB;
            end
            gbp_pkg::ST_TB_NB:
            begin
                cmd.op = gbp_pkg::OP_TB_NB;
                if (st.nb_ok)
                begin
                    state_next = gbp_pkg::ST_TB_NBW;
                end
                else if (st.dir_last)
                begin
                    state_next = gbp_pkg::ST_RESP;
                end
            end
            gbp_pkg::ST_TB_NBW:
            begin
                cmd.op = gbp_pkg::OP_TB_NBW;
                if (st.tb_match)
                begin
                    state_next = gbp_pkg::ST_TB_RD;
                end
                else if (st.dir_last)
                begin
                    state_next = gbp_pkg::ST_RESP;
                end
                else
                begin
                    state_next = gbp_pkg::ST_TB_NB;
                end
            end
            gbp_pkg::ST_RESP:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = gbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/gbp_datapath.sv
// ----------------------------------------------------------------------------
// gbp_datapath
// Cell store, frontier queue, configuration, neighbor walk and result fields.
// ----------------------------------------------------------------------------
module gbp_datapath
#(
    parameter int MAX_ROWS = gbp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gbp_pkg::DEF_MAX_COLS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  gbp_pkg::cmd_t                   cmd,
    output gbp_pkg::status_t                st,
    input  logic                            cfg_we,
    input  logic [gbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [gbp_pkg::KIND_W-1:0]      kind,
    input  logic [gbp_pkg::COORD_W-1:0]     cell_row,
    input  logic [gbp_pkg::COORD_W-1:0]     cell_col,
    input  logic                            wall_flag,
    output logic                            reachable,
    output logic [gbp_pkg::STEP_W-1:0]      step_count,
    output logic [gbp_pkg::CLASS_W-1:0]     cell_class,
    output logic [gbp_pkg::DIST_W-1:0]      cell_distance
);

    localparam int NUM_CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW = $clog2(NUM_CELLS);
    localparam int QW = $clog2(NUM_CELLS + 1);
    localparam int LW = $clog2(NUM_CELLS + 3);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int SRW = RW + 2;
    localparam int SCW = CW + 2;
    localparam logic [LW-1:0] CODE_WALL = {LW{1'b1}};
    localparam logic [LW-1:0] CODE_PATH = {LW{1'b1}} - LW'(1);
    localparam logic [LW-1:0] LABEL_ONE = LW'(1);

    function automatic logic [AW-1:0] cell_idx(input logic [RW-1:0] r, input logic [CW-1:0] c);
        cell_idx = AW'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    function automatic logic is_label(input logic [LW-1:0] v);
        is_label = (v != '0) && (v < CODE_PATH);
    endfunction

    logic [LW-1:0]      store_mem [NUM_CELLS];
    logic [RW+CW-1:0]   queue_mem [NUM_CELLS];
    logic [LW-1:0]      st_rd_reg;
    logic [RW+CW-1:0]   q_rd_reg;

    logic               st_we, st_re, q_we, q_re;
    logic [AW-1:0]      st_wa, st_ra, q_wa, q_ra;
    logic [LW-1:0]      st_wd;
    logic [RW+CW-1:0]   q_wd;

    logic [3:0]                 start_row_reg, start_col_reg, stop_row_reg, stop_col_reg;
    logic [gbp_pkg::LIMIT_W-1:0] rows_reg, cols_reg;

    logic [gbp_pkg::KIND_W-1:0]  kind_reg;
    logic [gbp_pkg::COORD_W-1:0] row_reg, col_reg;
    logic                        wall_reg;

    logic [AW-1:0]      clr_reg;
    logic [QW-1:0]      head_reg, tail_reg;
    logic               found_reg;
    logic [RW-1:0]      cur_row_reg;
    logic [CW-1:0]      cur_col_reg;
    logic [LW-1:0]      lab_reg;
    logic [2:0]         dir_reg;

    logic                        reach_reg;
    logic [gbp_pkg::STEP_W-1:0]  step_reg;
    logic [gbp_pkg::CLASS_W-1:0] class_reg;
    logic [gbp_pkg::DIST_W-1:0]  dist_reg;

    logic               item_in, start_in, stop_in;
    logic [AW-1:0]      item_idx, start_idx, stop_idx, nb_idx;
    logic signed [SRW-1:0] nr, rlim;
    logic signed [SCW-1:0] nc, clim;
    logic [RW-1:0]      nb_row;
    logic [CW-1:0]      nb_col;
    logic               nb_ok, stop_hit, cur_is_start;

    always_comb
    begin
        item_in   = (32'(row_reg) < MAX_ROWS) && (32'(col_reg) < MAX_COLS);
        start_in  = (32'(start_row_reg) < MAX_ROWS) && (32'(start_col_reg) < MAX_COLS);
        stop_in   = (32'(stop_row_reg) < MAX_ROWS) && (32'(stop_col_reg) < MAX_COLS);
        item_idx  = cell_idx(RW'(row_reg), CW'(col_reg));
        start_idx = cell_idx(RW'(start_row_reg), CW'(start_col_reg));
        stop_idx  = cell_idx(RW'(stop_row_reg), CW'(stop_col_reg));
        rlim = SRW'((32'(rows_reg) > MAX_ROWS) ? MAX_ROWS : 32'(rows_reg));
        clim = SCW'((32'(cols_reg) > MAX_COLS) ? MAX_COLS : 32'(cols_reg));
        nr = $signed({2'b00, cur_row_reg}) + SRW'(gbp_pkg::DIR_ROW[dir_reg]);
        nc = $signed({2'b00, cur_col_reg}) + SCW'(gbp_pkg::DIR_COL[dir_reg]);
        nb_ok  = (nr >= 0) && (nc >= 0) && (nr < rlim) && (nc < clim);
        nb_row = RW'(nr);
        nb_col = CW'(nc);
        nb_idx = cell_idx(nb_row, nb_col);
        stop_hit = (32'(nb_row) == 32'(stop_row_reg)) && (32'(nb_col) == 32'(stop_col_reg));
        cur_is_start = (32'(cur_row_reg) == 32'(start_row_reg))
                    && (32'(cur_col_reg) == 32'(start_col_reg));
    end

    always_comb
    begin
        st.kind     = kind_reg;
        st.clr_last = (clr_reg == AW'(NUM_CELLS - 1));
        st.start_in = start_in;
        st.stop_in  = stop_in;
        st.q_more   = (head_reg < tail_reg) && !found_reg;
        st.nb_ok    = nb_ok;
        st.dir_last = (dir_reg == 3'd7);
        st.tr_label = is_label(st_rd_reg);
        st.tb_end   = cur_is_start || !is_label(st_rd_reg) || (st_rd_reg <= LABEL_ONE);
        st.tb_match = (st_rd_reg == lab_reg - LABEL_ONE);
    end

    always_comb
    begin
        st_we = 1'b0;
        st_wa = clr_reg;
        st_wd = '0;
        st_re = 1'b0;
        st_ra = nb_idx;
        q_we  = 1'b0;
        q_wa  = tail_reg[AW-1:0];
        q_wd  = {nb_row, nb_col};
        q_re  = 1'b0;
        q_ra  = head_reg[AW-1:0];
        case (cmd.op)
            gbp_pkg::OP_CLEAR:
            begin
                st_we = 1'b1;
            end
            gbp_pkg::OP_WRITE:
            begin
                st_we = item_in;
                st_wa = item_idx;
                st_wd = wall_reg ? CODE_WALL : '0;
            end
            gbp_pkg::OP_RD_ISSUE:
            begin
                st_re = 1'b1;
                st_ra = item_idx;
            end
            gbp_pkg::OP_RUN_INIT:
            begin
                st_we = 1'b1;
                st_wa = start_idx;
                st_wd = LABEL_ONE;
                q_we  = 1'b1;
                q_wa  = '0;
                q_wd  = {RW'(start_row_reg), CW'(start_col_reg)};
            end
            gbp_pkg::OP_POP:
            begin
                q_re = 1'b1;
            end
            gbp_pkg::OP_LAB_RD:
            begin
                st_re = 1'b1;
                st_ra = cell_idx(q_rd_reg[RW+CW-1:CW], q_rd_reg[CW-1:0]);
            end
            gbp_pkg::OP_NB, gbp_pkg::OP_TB_NB:
            begin
                st_re = nb_ok;
            end
            gbp_pkg::OP_NB_WAIT:
            begin
                if ((st_rd_reg == '0) && (32'(tail_reg) < NUM_CELLS))
                begin
                    st_we = 1'b1;
                    st_wa = nb_idx;
                    st_wd = lab_reg + LABEL_ONE;
                    q_we  = 1'b1;
                end
            end
            gbp_pkg::OP_TR_RD:
            begin
                st_re = 1'b1;
                st_ra = stop_idx;
            end
            gbp_pkg::OP_TB_RD:
            begin
                st_re = 1'b1;
                st_ra = cell_idx(cur_row_reg, cur_col_reg);
            end
            gbp_pkg::OP_TB_CHK:
            begin
                st_we = 1'b1;
                st_wa = cell_idx(cur_row_reg, cur_col_reg);
                st_wd = CODE_PATH;
            end
            default:
            begin
                st_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_wa] <= st_wd;
        end
        if (st_re)
        begin
            st_rd_reg <= store_mem[st_ra];
        end
        if (q_we)
        begin
            queue_mem[q_wa] <= q_wd;
        end
        if (q_re)
        begin
            q_rd_reg <= queue_mem[q_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_row_reg <= '0;
            start_col_reg <= '0;
            stop_row_reg  <= '0;
            stop_col_reg  <= '0;
            rows_reg      <= gbp_pkg::ROWS_RESET;
            cols_reg      <= gbp_pkg::COLS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gbp_pkg::CFG_START_ROW: start_row_reg <= cfg_data[3:0];
                gbp_pkg::CFG_START_COL: start_col_reg <= cfg_data[3:0];
                gbp_pkg::CFG_STOP_ROW:  stop_row_reg  <= cfg_data[3:0];
                gbp_pkg::CFG_STOP_COL:  stop_col_reg  <= cfg_data[3:0];
                gbp_pkg::CFG_ROWS:      rows_reg      <= cfg_data;
                gbp_pkg::CFG_COLS:      cols_reg      <= cfg_data;
                default:                rows_reg      <= rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            found_reg <= 1'b0;
            dir_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                gbp_pkg::OP_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                end
                gbp_pkg::OP_RUN_INIT:
                begin
                    head_reg  <= '0;
                    tail_reg  <= QW'(1);
                    found_reg <= 1'b0;
                end
                gbp_pkg::OP_POP:
                begin
                    head_reg <= head_reg + QW'(1);
                end
                gbp_pkg::OP_LAB_WAIT, gbp_pkg::OP_TB_CHK:
                begin
                    dir_reg <= '0;
                end
                gbp_pkg::OP_NB, gbp_pkg::OP_TB_NB:
                begin
                    if (!nb_ok)
                    begin
                        dir_reg <= dir_reg + 3'd1;
                    end
                end
                gbp_pkg::OP_NB_WAIT:
                begin
                    dir_reg <= dir_reg + 3'd1;
                    if ((st_rd_reg == '0) && (32'(tail_reg) < NUM_CELLS))
                    begin
                        tail_reg <= tail_reg + QW'(1);
                        if (stop_hit)
                        begin
                            found_reg <= 1'b1;
                        end
                    end
                end
                gbp_pkg::OP_TB_NBW:
                begin
                    dir_reg <= dir_reg + 3'd1;
                end
                default:
                begin
                    clr_reg <= clr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            gbp_pkg::OP_LOAD:
            begin
                kind_reg  <= kind;
                row_reg   <= cell_row;
                col_reg   <= cell_col;
                wall_reg  <= wall_flag;
                reach_reg <= 1'b0;
                step_reg  <= '0;
                class_reg <= gbp_pkg::CLASS_FREE;
                dist_reg  <= '0;
            end
            gbp_pkg::OP_RD_DONE:
            begin
                if (item_in)
                begin
                    if (st_rd_reg == CODE_WALL)
                    begin
                        class_reg <= gbp_pkg::CLASS_WALL;
                    end
                    else if (st_rd_reg == CODE_PATH)
                    begin
                        class_reg <= gbp_pkg::CLASS_PATH;
                    end
                    else if (st_rd_reg != '0)
                    begin
                        class_reg <= gbp_pkg::CLASS_REACHED;
                        dist_reg  <= (32'(st_rd_reg) > 511) ? 9'd511
                                                           : gbp_pkg::DIST_W'(st_rd_reg);
                    end
                end
            end
            gbp_pkg::OP_LAB_RD:
            begin
                cur_row_reg <= q_rd_reg[RW+CW-1:CW];
                cur_col_reg <= q_rd_reg[CW-1:0];
            end
            gbp_pkg::OP_LAB_WAIT:
            begin
                lab_reg <= st_rd_reg;
            end
            gbp_pkg::OP_TR_CHK:
            begin
                cur_row_reg <= RW'(stop_row_reg);
                cur_col_reg <= CW'(stop_col_reg);
                if (is_label(st_rd_reg))
                begin
                    reach_reg <= 1'b1;
                    step_reg  <= (32'(st_rd_reg) - 1 > 255) ? 8'd255
                                 : gbp_pkg::STEP_W'(st_rd_reg - LABEL_ONE);
                end
            end
            gbp_pkg::OP_TB_CHK:
            begin
                lab_reg <= st_rd_reg;
            end
            gbp_pkg::OP_TB_NBW:
            begin
                if (st_rd_reg == lab_reg - LABEL_ONE)
                begin
                    cur_row_reg <= nb_row;
                    cur_col_reg <= nb_col;
                end
            end
            default:
            begin
                wall_reg <= wall_reg;
            end
        endcase
    end

    assign reachable     = reach_reg;
    assign step_count    = step_reg;
    assign cell_class    = class_reg;
    assign cell_distance = dist_reg;

endmodule

>>> rtl/grid_bfs_path_finder.sv
// ----------------------------------------------------------------------------
// grid_bfs_path_finder
// Lee-style 8-connected breadth-first router over a cell grid.
// ----------------------------------------------------------------------------
// Write: load, dispatch, response; a read adds a cell store read. One item is
// in flight at a time. Run: a flood from the start cell, then a trace back
// from the stop cell, walking the neighbors one at a time. After reset a
// clearing pass over all MAX_ROWS*MAX_COLS cells runs before the first
// transfer is taken; configuration writes are taken at any time.
module grid_bfs_path_finder
#(
    parameter int MAX_ROWS = gbp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gbp_pkg::DEF_MAX_COLS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [gbp_pkg::KIND_W-1:0]      kind,
    input  logic [gbp_pkg::COORD_W-1:0]     cell_row,
    input  logic [gbp_pkg::COORD_W-1:0]     cell_col,
    input  logic                            wall_flag,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            reachable,
    output logic [gbp_pkg::STEP_W-1:0]      step_count,
    output logic [gbp_pkg::CLASS_W-1:0]     cell_class,
    output logic [gbp_pkg::DIST_W-1:0]      cell_distance,
    input  logic                            cfg_we,
    input  logic [gbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    gbp_pkg::cmd_t    cmd;
    gbp_pkg::status_t st;

    gbp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    gbp_datapath
    #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .kind          (kind),
        .cell_row      (cell_row),
        .cell_col      (cell_col),
        .wall_flag     (wall_flag),
        .reachable     (reachable),
        .step_count    (step_count),
        .cell_class    (cell_class),
        .cell_distance (cell_distance)
    );

endmodule
